### design/wavhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wavhp_pkg;

  localparam int unsigned OUT_TDATA_W = 232;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [31:0] FMT_BODY_LEN = 32'd16;
  localparam logic [15:0] BITS_U8      = 16'd8;
  localparam logic [15:0] BITS_MAX     = 16'd32;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_RIFF   = 3'd1,
    ST_NOT_WAVE   = 3'd2,
    ST_NO_FMT     = 3'd3,
    ST_COMPRESSED = 3'd4,
    ST_TRUNCATED  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] riff_size;
    logic [15:0] audio_format;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
    logic        signed_samples;
    logic [31:0] half_scale;
  } result_t;

endpackage
`default_nettype wire

### design/wavhp_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module wavhp_in_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire wavhp_pkg::in_item_t in_item,
  output logic                    item_valid,
  output wavhp_pkg::in_item_t     item,
  input  wire logic               take
);

  logic                valid_r;
  logic                valid_nxt;
  wavhp_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

`ifndef SYNTHESIS
  a_take_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> valid_r)
    else $error("byte consumed from empty input register");
`endif

endmodule
`default_nettype wire

### design/wavhp_parse.sv
`timescale 1ns / 1ps
`default_nettype none
module wavhp_parse (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                item_valid,
  input  wire wavhp_pkg::in_item_t item,
  input  wire logic                out_free,
  output logic                     take,
  output logic                     res_valid,
  output wavhp_pkg::result_t       res
);

  typedef enum logic [3:0] {
    PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_FSIZE, PH_FBODY, PH_FSKIP,
    PH_CTAG, PH_CSIZE, PH_CSKIP, PH_DSIZE
  } phase_t;

  phase_t      phase_r, phase_nxt, cur_phase;
  logic [1:0]  bidx_r, bidx_nxt, cur_bidx;
  logic [31:0] shift_r, shift_nxt, cur_shift;
  logic [31:0] skip_r, skip_nxt, cur_skip;
  logic [31:0] fmtr_r, fmtr_nxt, cur_fmtr;
  logic [7:0]  ff_r [16];
  logic [7:0]  ff_nxt [16];
  logic [7:0]  cur_ff [16];
  logic [31:0] size_r, size_nxt, cur_size;
  logic        fin_r, fin_nxt, cur_fin;
  logic [3:0]  bcnt_r, bcnt_nxt, cur_bcnt;

  logic              hit;
  wavhp_pkg::status_t st;
  logic [31:0]       dsize;
  logic              word_done;
  logic [15:0]       bits;
  logic [15:0]       bits_m1;

  always_comb begin
    cur_phase = item.first_byte ? PH_RIFF : phase_r;
    cur_bidx  = item.first_byte ? 2'd0 : bidx_r;
    cur_shift = item.first_byte ? 32'd0 : shift_r;
    cur_skip  = item.first_byte ? 32'd0 : skip_r;
    cur_fmtr  = item.first_byte ? 32'd0 : fmtr_r;
    cur_size  = item.first_byte ? 32'd0 : size_r;
    cur_fin   = item.first_byte ? 1'b0 : fin_r;
    cur_bcnt  = item.first_byte ? 4'd0 : bcnt_r;
    for (int i = 0; i < 16; i++) begin
      cur_ff[i] = item.first_byte ? 8'd0 : ff_r[i];
    end
  end

  always_comb begin
    phase_nxt = cur_phase;
    bidx_nxt  = cur_bidx;
    shift_nxt = cur_shift;
    skip_nxt  = cur_skip;
    fmtr_nxt  = cur_fmtr;
    size_nxt  = cur_size;
    fin_nxt   = cur_fin;
    bcnt_nxt  = cur_bcnt;
    ff_nxt    = cur_ff;
    hit       = 1'b0;
    st        = wavhp_pkg::ST_OK;
    dsize     = 32'd0;
    word_done = 1'b0;
    if (!cur_fin) begin
      if (cur_phase != PH_FBODY && cur_phase != PH_FSKIP && cur_phase != PH_CSKIP) begin
        shift_nxt = {item.data_byte, cur_shift[31:8]};
        word_done = (cur_bidx == 2'd3);
        bidx_nxt  = cur_bidx + 2'd1;
      end
      unique case (cur_phase)
        PH_RIFF: begin
          if (word_done) begin
            if (shift_nxt != wavhp_pkg::TAG_RIFF) begin
              hit = 1'b1;
              st  = wavhp_pkg::ST_NOT_RIFF;
            end else begin
              phase_nxt = PH_RSIZE;
            end
          end
        end
        PH_RSIZE: begin
          if (word_done) begin
            size_nxt  = shift_nxt;
            phase_nxt = PH_WAVE;
          end
        end
        PH_WAVE: begin
          if (word_done) begin
            if (shift_nxt != wavhp_pkg::TAG_WAVE) begin
              hit = 1'b1;
              st  = wavhp_pkg::ST_NOT_WAVE;
            end else begin
              phase_nxt = PH_FMT;
            end
          end
        end
        PH_FMT: begin
          if (word_done) begin
            if (shift_nxt != wavhp_pkg::TAG_FMT) begin
              hit = 1'b1;
              st  = wavhp_pkg::ST_NO_FMT;
            end else begin
              phase_nxt = PH_FSIZE;
            end
          end
        end
        PH_FSIZE: begin
          if (word_done) begin
            fmtr_nxt  = shift_nxt;
            bcnt_nxt  = 4'd0;
            phase_nxt = PH_FBODY;
          end
        end
        PH_FBODY: begin
          ff_nxt[cur_bcnt] = item.data_byte;
          bcnt_nxt         = cur_bcnt + 4'd1;
          if (cur_bcnt == 4'd15) begin
            if ({ff_nxt[1], ff_nxt[0]} != wavhp_pkg::FMT_PCM) begin
              hit = 1'b1;
              st  = wavhp_pkg::ST_COMPRESSED;
            end else if (cur_fmtr > wavhp_pkg::FMT_BODY_LEN) begin
              fmtr_nxt  = cur_fmtr - wavhp_pkg::FMT_BODY_LEN;
              phase_nxt = PH_FSKIP;
            end else begin
              fmtr_nxt  = 32'd0;
              phase_nxt = PH_CTAG;
            end
          end
        end
        PH_FSKIP: begin
          fmtr_nxt = cur_fmtr - 32'd1;
          if (fmtr_nxt == 32'd0) begin
            phase_nxt = PH_CTAG;
          end
        end
        PH_CTAG: begin
          if (word_done) begin
            phase_nxt = (shift_nxt == wavhp_pkg::TAG_DATA) ? PH_DSIZE : PH_CSIZE;
          end
        end
        PH_CSIZE: begin
          if (word_done) begin
            skip_nxt  = shift_nxt;
            phase_nxt = (shift_nxt == 32'd0) ? PH_CTAG : PH_CSKIP;
          end
        end
        PH_CSKIP: begin
          skip_nxt = cur_skip - 32'd1;
          if (skip_nxt == 32'd0) begin
            phase_nxt = PH_CTAG;
          end
        end
        PH_DSIZE: begin
          if (word_done) begin
            hit   = 1'b1;
            st    = wavhp_pkg::ST_OK;
            dsize = shift_nxt;
          end
        end
        default: begin
          phase_nxt = PH_RIFF;
        end
      endcase
      if (!hit && item.end_of_file) begin
        hit = 1'b1;
        st  = wavhp_pkg::ST_TRUNCATED;
      end
      if (hit) begin
        fin_nxt = 1'b1;
      end
    end
  end

  assign take      = item_valid && (!hit || out_free);
  assign res_valid = item_valid && hit && out_free;

  assign bits    = {ff_nxt[15], ff_nxt[14]};
  assign bits_m1 = bits - 16'd1;

  always_comb begin
    res.status          = st;
    res.riff_size       = size_nxt;
    res.audio_format    = {ff_nxt[1], ff_nxt[0]};
    res.channel_count   = {ff_nxt[3], ff_nxt[2]};
    res.sample_rate     = {ff_nxt[7], ff_nxt[6], ff_nxt[5], ff_nxt[4]};
    res.byte_rate       = {ff_nxt[11], ff_nxt[10], ff_nxt[9], ff_nxt[8]};
    res.block_align     = {ff_nxt[13], ff_nxt[12]};
    res.bits_per_sample = bits;
    res.data_size       = dsize;
    res.signed_samples  = (bits != wavhp_pkg::BITS_U8);
    res.half_scale      = (bits != 16'd0 && bits <= wavhp_pkg::BITS_MAX) ?
                          (32'd1 << bits_m1[4:0]) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF;
      bidx_r  <= 2'd0;
      shift_r <= 32'd0;
      skip_r  <= 32'd0;
      fmtr_r  <= 32'd0;
      size_r  <= 32'd0;
      fin_r   <= 1'b0;
      bcnt_r  <= 4'd0;
      for (int i = 0; i < 16; i++) begin
        ff_r[i] <= 8'd0;
      end
    end else if (take) begin
      phase_r <= phase_nxt;
      bidx_r  <= bidx_nxt;
      shift_r <= shift_nxt;
      skip_r  <= skip_nxt;
      fmtr_r  <= fmtr_nxt;
      size_r  <= size_nxt;
      fin_r   <= fin_nxt;
      bcnt_r  <= bcnt_nxt;
      ff_r    <= ff_nxt;
    end
  end

`ifndef SYNTHESIS
  a_done_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> fin_r)
    else $error("parser not marked finished after result");
  a_raw_phase_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FBODY || phase_r == PH_FSKIP || phase_r == PH_CSKIP) |-> bidx_r == 2'd0)
    else $error("tag byte index not aligned in raw byte phase");
  a_cskip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_CSKIP) |-> skip_r != 32'd0)
    else $error("chunk skip with zero count");
  a_fskip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FSKIP) |-> fmtr_r != 32'd0)
    else $error("fmt skip with zero count");
`endif

endmodule
`default_nettype wire

### design/wavhp_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none
module wavhp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               res_valid,
  input  wire wavhp_pkg::result_t res,
  output logic                    out_free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output wavhp_pkg::result_t      out_res
);

  logic               valid_r;
  logic               valid_nxt;
  wavhp_pkg::result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (res_valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (res_valid) begin
      res_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (!valid_r || out_ready))
    else $error("result register overwritten while held");
`endif

endmodule
`default_nettype wire

### design/wav_header_parser.sv
// wav header parser
// in_*  : one file byte per word. in_tdata[7:0] is the byte, in_tuser marks the
//         first byte of a new file (parse state restarts at that byte), in_tlast
//         marks the last byte of the stream.
// out_* : one word per parsed file, carrying the status, the format fields, the
//         data chunk size, the sample signedness and the half-scale offset.
//         A file ends in exactly one word: on the data size, on a tag or format
//         error, or on in_tlast. Bytes after that are dropped until in_tuser.
// path:   a byte lands in the input register, is parsed from there, and its result
//         word is registered in the output register that drives out_tvalid.
// throughput: one byte per cycle unless a result waits; the whole header update
//         is a single pass through the parse logic between the two registers.
// stall: while a result word waits on out_tready, bytes that make no result
//         keep flowing; only a byte that would make a new result waits in the
//         input register, and in_tready drops behind it.
// reset: rst_n low clears the valid flags of both registers and the parse state
//         to the start of a file; no word is presented until bytes arrive.
`timescale 1ns / 1ps
`default_nettype none
module wav_header_parser (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // data_byte
  input  wire logic                              in_tuser,   // first_byte
  input  wire logic                              in_tlast,   // end_of_file
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // status, riff_size, audio_format, channel_count, sample_rate, byte_rate,
  // block_align, bits_per_sample, data_size, signed_samples, half_scale, pad
  output logic [wavhp_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  wavhp_pkg::in_item_t in_item;
  wavhp_pkg::in_item_t item;
  wavhp_pkg::result_t  res;
  wavhp_pkg::result_t  out_res;
  logic                item_valid;
  logic                take;
  logic                res_valid;
  logic                out_free;

  assign in_item.data_byte   = in_tdata;
  assign in_item.first_byte  = in_tuser;
  assign in_item.end_of_file = in_tlast;

  wavhp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  wavhp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .out_free   (out_free),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res)
  );

  wavhp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'b0000,
                      out_res.half_scale,
                      out_res.signed_samples,
                      out_res.data_size,
                      out_res.bits_per_sample,
                      out_res.block_align,
                      out_res.byte_rate,
                      out_res.sample_rate,
                      out_res.channel_count,
                      out_res.audio_format,
                      out_res.riff_size,
                      3'(out_res.status)};

endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef enum logic [3:0] {
    PS_RIFF, PS_RSIZE, PS_WAVE, PS_FMT, PS_FSIZE, PS_FBODY, PS_FSKIP,
    PS_CTAG, PS_CSIZE, PS_CSKIP, PS_DSIZE
  } parse_stage_t;

  class wav_scoreboard;
    parse_stage_t         stage;
    int                   tag_cnt;
    logic [31:0]          shreg;
    logic [31:0]          chunk_left;
    logic [31:0]          fmt_left;
    logic [7:0]           fmt_bytes[16];
    int                   body_cnt;
    logic [31:0]          riff_len;
    bit                   done;
    wavhp_pkg::result_t   expq[$];
    int                   errors;
    int                   n_bytes;
    int                   n_expected;
    int                   n_words;
    int                   status_seen[6];

    function new();
      restart();
    endfunction

    function void restart();
      stage = PS_RIFF;
      tag_cnt = 0;
      shreg = '0;
      chunk_left = '0;
      fmt_left = '0;
      foreach (fmt_bytes[i]) fmt_bytes[i] = '0;
      body_cnt = 0;
      riff_len = '0;
      done = 0;
    endfunction

    function void note_byte(logic [7:0] b, logic f, logic l);
      wavhp_pkg::result_t r;
      wavhp_pkg::status_t st;
      bit                 fin;
      bit                 word_done;
      logic [31:0]        dsz;
      logic [15:0]        bits;
      n_bytes++;
      if (f) restart();
      if (done) return;
      st = wavhp_pkg::ST_TRUNCATED;
      fin = 0;
      word_done = 0;
      dsz = '0;
      if (stage != PS_FBODY && stage != PS_FSKIP && stage != PS_CSKIP) begin
        shreg = {b, shreg[31:8]};
        tag_cnt++;
        if (tag_cnt >= 4) begin
          tag_cnt = 0;
          word_done = 1;
        end
      end
      case (stage)
        PS_RIFF: if (word_done) begin
          if (shreg != wavhp_pkg::TAG_RIFF) begin
            fin = 1;
            st = wavhp_pkg::ST_NOT_RIFF;
          end else stage = PS_RSIZE;
        end
        PS_RSIZE: if (word_done) begin
          riff_len = shreg;
          stage = PS_WAVE;
        end
        PS_WAVE: if (word_done) begin
          if (shreg != wavhp_pkg::TAG_WAVE) begin
            fin = 1;
            st = wavhp_pkg::ST_NOT_WAVE;
          end else stage = PS_FMT;
        end
        PS_FMT: if (word_done) begin
          if (shreg != wavhp_pkg::TAG_FMT) begin
            fin = 1;
            st = wavhp_pkg::ST_NO_FMT;
          end else stage = PS_FSIZE;
        end
        PS_FSIZE: if (word_done) begin
          fmt_left = shreg;
          body_cnt = 0;
          stage = PS_FBODY;
        end
        PS_FBODY: begin
          fmt_bytes[body_cnt & 15] = b;
          body_cnt++;
          if (body_cnt >= 16) begin
            body_cnt = 0;
            if ({fmt_bytes[1], fmt_bytes[0]} != wavhp_pkg::FMT_PCM) begin
              fin = 1;
              st = wavhp_pkg::ST_COMPRESSED;
            end else if (fmt_left > wavhp_pkg::FMT_BODY_LEN) begin
              fmt_left = fmt_left - wavhp_pkg::FMT_BODY_LEN;
              stage = PS_FSKIP;
            end else begin
              fmt_left = '0;
              stage = PS_CTAG;
            end
          end
        end
        PS_FSKIP: begin
          fmt_left = fmt_left - 32'd1;
          if (fmt_left == 0) stage = PS_CTAG;
        end
        PS_CTAG: if (word_done) begin
          stage = (shreg == wavhp_pkg::TAG_DATA) ? PS_DSIZE : PS_CSIZE;
        end
        PS_CSIZE: if (word_done) begin
          chunk_left = shreg;
          stage = (chunk_left == 0) ? PS_CTAG : PS_CSKIP;
        end
        PS_CSKIP: begin
          chunk_left = chunk_left - 32'd1;
          if (chunk_left == 0) stage = PS_CTAG;
        end
        PS_DSIZE: if (word_done) begin
          dsz = shreg;
          fin = 1;
          st = wavhp_pkg::ST_OK;
        end
        default: stage = PS_RIFF;
      endcase
      if (!fin && l) fin = 1;
      if (!fin) return;
      done = 1;
      bits = {fmt_bytes[15], fmt_bytes[14]};
      r.status          = st;
      r.riff_size       = riff_len;
      r.audio_format    = {fmt_bytes[1], fmt_bytes[0]};
      r.channel_count   = {fmt_bytes[3], fmt_bytes[2]};
      r.sample_rate     = {fmt_bytes[7], fmt_bytes[6], fmt_bytes[5], fmt_bytes[4]};
      r.byte_rate       = {fmt_bytes[11], fmt_bytes[10], fmt_bytes[9], fmt_bytes[8]};
      r.block_align     = {fmt_bytes[13], fmt_bytes[12]};
      r.bits_per_sample = bits;
      r.data_size       = dsz;
      r.signed_samples  = (bits == wavhp_pkg::BITS_U8) ? 1'b0 : 1'b1;
      r.half_scale      = (bits >= 16'd1 && bits <= wavhp_pkg::BITS_MAX) ?
                          (32'd1 << (bits - 16'd1)) : '0;
      expq.push_back(r);
      n_expected++;
    endfunction

    function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %0h, got %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_word(logic [wavhp_pkg::OUT_TDATA_W-1:0] w);
      wavhp_pkg::result_t e;
      if (expq.size() == 0) begin
        $error("result word with nothing expected: %h", w);
        errors++;
        return;
      end
      e = expq.pop_front();
      n_words++;
      status_seen[e.status]++;
      cmp_field("status", 32'(e.status), 32'(w[2:0]));
      cmp_field("riff_size", e.riff_size, w[34:3]);
      cmp_field("audio_format", 32'(e.audio_format), 32'(w[50:35]));
      cmp_field("channel_count", 32'(e.channel_count), 32'(w[66:51]));
      cmp_field("sample_rate", e.sample_rate, w[98:67]);
      cmp_field("byte_rate", e.byte_rate, w[130:99]);
      cmp_field("block_align", 32'(e.block_align), 32'(w[146:131]));
      cmp_field("bits_per_sample", 32'(e.bits_per_sample), 32'(w[162:147]));
      cmp_field("data_size", e.data_size, w[194:163]);
      cmp_field("signed_samples", 32'(e.signed_samples), 32'(w[195]));
      cmp_field("half_scale", e.half_scale, w[227:196]);
    endfunction
  endclass

  logic                              clk;
  logic                              rst_n;
  logic                              in_tvalid;
  logic                              in_tready;
  logic [7:0]                        in_tdata;
  logic                              in_tuser;
  logic                              in_tlast;
  logic                              out_tvalid;
  logic                              out_tready;
  logic [wavhp_pkg::OUT_TDATA_W-1:0] out_tdata;

  wav_scoreboard sb = new();
  logic [7:0]    file_q[$];
  bit            quiet;
  int            idle_cycles;

  wav_header_parser u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function void put16(logic [15:0] v);
    file_q.push_back(v[7:0]);
    file_q.push_back(v[15:8]);
  endfunction

  function void put32(logic [31:0] v);
    put16(v[15:0]);
    put16(v[31:16]);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = f;
    in_tlast  = l;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_byte(b, f, l);
    @(negedge clk);
  endtask

  task automatic send_file(input int eof_at);
    for (int i = 0; i < file_q.size(); i++) begin
      send_byte(file_q[i], i == 0, i == eof_at);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  // watchdog on handshake activity
  initial begin
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  // result side backpressure, with one long hold-off
  initial begin
    int n;
    bit squeezed;
    squeezed = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (!squeezed && sb.n_words >= 6) begin
        squeezed = 1;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if ($urandom_range(0, 4) == 0) begin
        out_tready = 1'b1;
        repeat ($urandom_range(30, 100)) @(negedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_tready = 1'b0;
          repeat (n) @(negedge clk);
        end
        out_tready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  initial begin
    int          r;
    int          idx;
    int          eof_at;
    int          fsz;
    int          csz;
    int          n_files;
    logic [15:0] fmt_code;
    logic [15:0] bits;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    in_tlast   = 1'b0;
    out_tready = 1'b0;
    quiet      = 0;
    n_files    = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // bad riff tag, then bytes dropped after the result
    file_q.delete();
    put32({8'h58, wavhp_pkg::TAG_RIFF[23:0]});
    send_file(-1);
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    // lone byte marked first and last
    file_q.delete();
    file_q.push_back(8'h00);
    send_file(0);
    // bad wave tag
    file_q.delete();
    put32(wavhp_pkg::TAG_RIFF);
    put32(32'hFFFF_FFFF);
    put32({8'h58, wavhp_pkg::TAG_WAVE[23:0]});
    send_file(-1);
    // stream ends inside the riff size
    file_q.delete();
    put32(wavhp_pkg::TAG_RIFF);
    put16(16'hA55A);
    send_file(5);
    n_files = 4;

    while (sb.n_bytes < 1300) begin
      quiet = ($urandom_range(0, 4) == 0);
      file_q.delete();
      put32(wavhp_pkg::TAG_RIFF);
      put32($urandom);
      put32(wavhp_pkg::TAG_WAVE);
      put32(wavhp_pkg::TAG_FMT);
      r = $urandom_range(0, 99);
      if (r < 60) fsz = 16;
      else if (r < 75) fsz = $urandom_range(0, 15);
      else fsz = $urandom_range(17, 24);
      put32(fsz);
      r = $urandom_range(0, 99);
      if (r < 85) fmt_code = wavhp_pkg::FMT_PCM;
      else if (r < 89) fmt_code = 16'h0000;
      else if (r < 93) fmt_code = 16'hFFFF;
      else fmt_code = 16'($urandom_range(2, 65535));
      put16(fmt_code);
      put16(16'($urandom));
      put32($urandom);
      put32($urandom);
      put16(16'($urandom));
      case ($urandom_range(0, 9))
        0: bits = 16'd8;
        1: bits = 16'd16;
        2: bits = 16'd24;
        3: bits = 16'd32;
        4: bits = 16'd1;
        5: bits = 16'd0;
        6: bits = 16'd33;
        7: bits = 16'hFFFF;
        default: bits = 16'($urandom_range(0, 65535));
      endcase
      put16(bits);
      if (fsz > 16) repeat (fsz - 16) file_q.push_back(8'($urandom));
      repeat ($urandom_range(0, 2)) begin
        put32($urandom);
        csz = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        put32(csz);
        repeat (csz) file_q.push_back(8'($urandom));
      end
      put32(wavhp_pkg::TAG_DATA);
      put32($urandom);

      eof_at = -1;
      r = $urandom_range(0, 99);
      if (r < 65) begin
        if ($urandom_range(0, 3) == 0) eof_at = file_q.size() - 1;
      end else if (r < 80) begin
        case ($urandom_range(0, 4))
          0: idx = $urandom_range(0, 3);
          1: idx = $urandom_range(8, 11);
          2: idx = $urandom_range(12, 15);
          3: idx = 20;
          default: idx = $urandom_range(0, file_q.size() - 1);
        endcase
        file_q[idx] = file_q[idx] ^ 8'($urandom_range(1, 255));
        if ($urandom_range(0, 1) == 1) eof_at = file_q.size() - 1;
      end else if (r < 92) begin
        eof_at = $urandom_range(0, file_q.size() - 1);
      end else begin
        file_q.delete();
        repeat ($urandom_range(1, 24)) file_q.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 1) eof_at = $urandom_range(0, file_q.size() - 1);
      end
      send_file(eof_at);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
      n_files++;
    end

    in_tvalid = 1'b0;
    while (sb.expq.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d bytes in %0d streams, %0d header words checked",
             sb.n_bytes, n_files, sb.n_words);
    $display("status mix: ok %0d, not riff %0d, not wave %0d, no fmt %0d,",
             sb.status_seen[wavhp_pkg::ST_OK], sb.status_seen[wavhp_pkg::ST_NOT_RIFF],
             sb.status_seen[wavhp_pkg::ST_NOT_WAVE], sb.status_seen[wavhp_pkg::ST_NO_FMT],
             " compressed %0d, truncated %0d",
             sb.status_seen[wavhp_pkg::ST_COMPRESSED],
             sb.status_seen[wavhp_pkg::ST_TRUNCATED]);
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### wav_header_parser.f
design/wavhp_pkg.sv
design/wavhp_in_stage.sv
design/wavhp_parse.sv
design/wavhp_out_stage.sv
design/wav_header_parser.sv
test/tb.sv
